[design/itaf_pkg.sv]
// Shared types and constants for the integer-to-ASCII formatter.
// No dependencies; every other file in design/ uses this package.
package itaf_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int BCD_DIGITS  = 5;
   localparam int BCD_WIDTH   = 4 * BCD_DIGITS;
   localparam int CONV_STEPS  = VALUE_WIDTH;

   // conversion selector codes
   localparam logic [1:0] FUNC_SDEC = 2'd0;
   localparam logic [1:0] FUNC_UDEC = 2'd1;
   localparam logic [1:0] FUNC_HEX  = 2'd2;

   // ASCII codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UPPER = 8'h41;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam logic [3:0] NIB_TEN    = 4'd10;

   // digit counts
   localparam logic [2:0] DEC_CHARS  = 3'd5;
   localparam logic [2:0] HEX_CHARS  = 3'd4;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request payload
      logic bit_shift;  // one double-dabble step
      logic nib_shift;  // drop the top digit
      logic emit;       // load the output character register
      logic emit_sign;  // character is '-' instead of the top digit
      logic emit_last;  // mark this character as the final one
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] mode;
      logic       neg;
      logic       top_zero;
   } status_type;

endpackage

[design/itaf_channels.sv]
// Handshake channel interfaces for the formatter: request and response.
// Depends on itaf_pkg for field widths.
interface itaf_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          func;
   logic [itaf_pkg::VALUE_WIDTH-1:0]    value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface itaf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       last;

   modport source (output valid, output text_char, output last, input ready);
   modport sink   (input valid, input text_char, input last, output ready);
endinterface

[design/itaf_datapath.sv]
// Datapath: sign handling, bit-serial binary-to-BCD conversion, digit
// register and the output character register. Depends on itaf_pkg.
module itaf_datapath (
   input  logic                             clock,
   input  logic [1:0]                       in_func,
   input  logic [itaf_pkg::VALUE_WIDTH-1:0] in_value,
   input  itaf_pkg::cmd_type                cmd,
   output itaf_pkg::status_type             status,
   output logic [7:0]                       text_char,
   output logic                             last
);

   logic [1:0]                          mode_ff, mode_in;
   logic                                neg_ff, neg_in;
   logic [itaf_pkg::VALUE_WIDTH-1:0]    mag_ff, mag_in;
   logic [itaf_pkg::BCD_WIDTH-1:0]      dig_ff, dig_in;
   logic [7:0]                          char_ff, char_in;
   logic                                last_ff, last_in;
   logic [itaf_pkg::BCD_WIDTH-1:0]      adj;
   logic [3:0]                          top_nib;
   logic                                in_neg;

   assign in_neg  = (in_func == itaf_pkg::FUNC_SDEC) && in_value[itaf_pkg::VALUE_WIDTH-1];
   assign top_nib = dig_ff[itaf_pkg::BCD_WIDTH-1 -: 4];

   // add-3 correction on every BCD digit that is 5 or more
   always_comb begin
      for (int i = 0; i < itaf_pkg::BCD_DIGITS; i++) begin
         if (dig_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = dig_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = dig_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      mode_in = mode_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      dig_in  = dig_ff;
      char_in = char_ff;
      last_in = last_ff;
      if (cmd.load) begin
         mode_in = in_func;
         neg_in  = in_neg;
         mag_in  = in_neg ? (~in_value) + 16'd1 : in_value;
         if (in_func == itaf_pkg::FUNC_HEX) begin
            dig_in = {in_value, 4'd0};
         end else begin
            dig_in = '0;
         end
      end else if (cmd.bit_shift) begin
         dig_in = {adj[itaf_pkg::BCD_WIDTH-2:0], mag_ff[itaf_pkg::VALUE_WIDTH-1]};
         mag_in = {mag_ff[itaf_pkg::VALUE_WIDTH-2:0], 1'b0};
      end else if (cmd.nib_shift) begin
         dig_in = {dig_ff[itaf_pkg::BCD_WIDTH-5:0], 4'd0};
      end
      if (cmd.emit) begin
         last_in = cmd.emit_last;
         if (cmd.emit_sign) begin
            char_in = itaf_pkg::CHAR_MINUS;
         end else if (top_nib >= itaf_pkg::NIB_TEN) begin
            char_in = itaf_pkg::CHAR_UPPER + {4'd0, top_nib - itaf_pkg::NIB_TEN};
         end else begin
            char_in = itaf_pkg::CHAR_ZERO + {4'd0, top_nib};
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      dig_ff  <= dig_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign status.mode     = mode_ff;
   assign status.neg      = neg_ff;
   assign status.top_zero = (top_nib == 4'd0);
   assign text_char       = char_ff;
   assign last            = last_ff;

endmodule

[design/itaf_controller.sv]
// Controller state machine: request handshake, conversion sequencing,
// leading-zero skip and output valid. Depends on itaf_pkg.
module itaf_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  itaf_pkg::status_type status,
   output itaf_pkg::cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_CONV   = 6'b000100,
      ST_ALIGN  = 6'b001000,
      ST_SIGN   = 6'b010000,
      ST_DIGIT  = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [2:0] count_ff, count_in;
   logic       valid_ff, valid_in;
   logic       slot_free;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      count_in = count_ff;
      cmd      = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            step_in = 4'd0;
            if (status.mode == itaf_pkg::FUNC_HEX) begin
               count_in = itaf_pkg::HEX_CHARS;
               state_in = ST_DIGIT;
            end else if (status.mode == itaf_pkg::FUNC_SDEC ||
                         status.mode == itaf_pkg::FUNC_UDEC) begin
               state_in = ST_CONV;
            end else begin
               state_in = ST_IDLE;    // unused selector: no text
            end
         end
         ST_CONV: begin
            cmd.bit_shift = 1'b1;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(itaf_pkg::CONV_STEPS - 1)) begin
               count_in = itaf_pkg::DEC_CHARS;
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            // drop leading zeros, keep at least one digit
            if (status.top_zero && count_ff > 3'd1) begin
               cmd.nib_shift = 1'b1;
               count_in = count_ff - 3'd1;
            end else if (status.neg) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sign = 1'b1;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (slot_free) begin
               cmd.emit      = 1'b1;
               cmd.nib_shift = 1'b1;
               cmd.emit_last = (count_ff == 3'd1);
               count_in = count_ff - 3'd1;
               if (count_ff == 3'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         step_ff  <= 4'd0;
         count_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         step_ff  <= step_in;
         count_ff <= count_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

[design/integer_to_ascii_formatter_unit.sv]
// Top level of the integer-to-ASCII formatter: controller plus datapath.
// Depends on itaf_pkg, itaf_channels, itaf_controller, itaf_datapath.
//
// Each request transfer carries a 16-bit value and a selector (0 signed
// decimal, 1 unsigned decimal, 2 four-digit uppercase hex; 3 yields no
// text). The value's text leaves on the response channel one character per
// transfer, most significant first, with last set on the final character.
// One request is worked at a time. Hex captures and decodes the request,
// then emits one character per cycle while the response channel takes them.
// Decimal runs a bit-serial double-dabble conversion, one bit per cycle
// over all 16 bits of the magnitude, then skips one leading zero per cycle
// and leaves the skip, then emits the optional '-' and the digits one per
// cycle while the response channel takes them.
// The character register parts the two sides: a new request is taken as
// soon as the final character is loaded, even while it still waits.
// A stalled response channel simply holds the emitting states.
module integer_to_ascii_formatter_unit (
   input  logic        clock,
   input  logic        reset,
   itaf_req_if.sink    req_chan,
   itaf_rsp_if.source  rsp_chan
);

   itaf_pkg::cmd_type    cmd;
   itaf_pkg::status_type status;

   // sequencing: handshakes, step counts, leading-zero skip
   itaf_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // payload: magnitude, BCD digits, output character
   itaf_datapath u_dp (
      .clock     (clock),
      .in_func   (req_chan.func),
      .in_value  (req_chan.value),
      .cmd       (cmd),
      .status    (status),
      .text_char (rsp_chan.text_char),
      .last      (rsp_chan.last)
   );

endmodule
